@@ sv/tofp_pkg.sv @@
// package: shared types and constants for the first-fit offset planner
`timescale 1ns / 1ps
package tofp_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int ADDR_BITS_DEFAULT   = 32;
   localparam int STEP_BITS_DEFAULT   = 16;
   localparam int SIZE_W              = 32;
   localparam int STEP_W              = 16;
   localparam int OUT_W               = 32;
   localparam int ALIGN_W             = 4;
   localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd6;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRUNE,
      ST_CHECK,
      ST_SEARCH,
      ST_FETCH,
      ST_STEP,
      ST_PLACE,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PRUNE,
      OP_CHECK,
      OP_SEARCH,
      OP_FETCH,
      OP_STEP,
      OP_PLACE,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic has_free;
      logic found;
      logic fits;
      logic rsp_free;
   } stat_type;

endpackage

@@ sv/tofp_if.sv @@
// interfaces: request and response channels
`timescale 1ns / 1ps
interface tofp_req_if import tofp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              new_plan;
   logic [SIZE_W-1:0] buffer_size;
   logic [STEP_W-1:0] def_step;
   logic [STEP_W-1:0] last_use_step;

   modport source (output valid, new_plan, buffer_size, def_step, last_use_step, input ready);
   modport sink (input valid, new_plan, buffer_size, def_step, last_use_step, output ready);
endinterface

interface tofp_rsp_if import tofp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] offset;
   logic [OUT_W-1:0] peak_bytes;
   logic [1:0]       status;

   modport source (output valid, offset, peak_bytes, status, input ready);
   modport sink (input valid, offset, peak_bytes, status, output ready);
endinterface

@@ sv/tofp_controller.sv @@
// controller: sequences prune, ordered search, placement and response
`timescale 1ns / 1ps
module tofp_controller import tofp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_PRUNE;
            end
         end
         ST_PRUNE: begin
            cmd.op = OP_PRUNE;
            if (stat.sweep_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.op   = OP_CHECK;
            state_in = stat.has_free ? ST_SEARCH : ST_FINISH;
         end
         ST_SEARCH: begin
            cmd.op = OP_SEARCH;
            if (stat.sweep_done) state_in = stat.found ? ST_FETCH : ST_PLACE;
         end
         ST_FETCH: begin
            cmd.op   = OP_FETCH;
            state_in = stat.fits ? ST_PLACE : ST_STEP;
         end
         ST_STEP: begin
            cmd.op   = OP_STEP;
            state_in = ST_SEARCH;
         end
         ST_PLACE: begin
            cmd.op   = OP_PLACE;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ sv/tofp_datapath.sv @@
// datapath: interval memories, sweep counter, first-fit arithmetic, response register
`timescale 1ns / 1ps
module tofp_datapath import tofp_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
   parameter int ADDR_BITS   = ADDR_BITS_DEFAULT,
   parameter int STEP_BITS   = STEP_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               csr_write_enable,
   input  logic [ALIGN_W-1:0] csr_write_data,
   input  logic               in_new_plan,
   input  logic [SIZE_W-1:0]  in_buffer_size,
   input  logic [STEP_W-1:0]  in_def_step,
   input  logic [STEP_W-1:0]  in_last_use_step,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [OUT_W-1:0]   rsp_offset,
   output logic [OUT_W-1:0]   rsp_peak_bytes,
   output logic [1:0]         rsp_status
);

   localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int CALC = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 2;
   localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

   logic [ADDR_BITS-1:0] off_mem  [TABLE_DEPTH];
   logic [ADDR_BITS-1:0] end_mem  [TABLE_DEPTH];
   logic [STEP_BITS-1:0] last_mem [TABLE_DEPTH];

   logic [ADDR_BITS-1:0] rd_off_ff, rd_end_ff;
   logic [STEP_BITS-1:0] rd_last_ff;

   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [STEP_BITS-1:0] def_ff, def_in, last_ff, last_in;
   logic [CALC-1:0]      cand_ff, cand_in;
   logic                 started_ff, started_in;
   logic [ADDR_BITS-1:0] prev_off_ff, prev_off_in, best_off_ff, best_off_in;
   logic [IW-1:0]        prev_idx_ff, prev_idx_in, best_ff, best_in, free_ff, free_in;
   logic                 found_ff, found_in, has_free_ff, has_free_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 pv_ff, pv_in;
   logic [IW-1:0]        pidx_ff, pidx_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [ADDR_BITS-1:0] peak_ff, peak_in;
   logic [ALIGN_W-1:0]   align_ff, align_in;
   logic [OUT_W-1:0]     res_off_ff, res_off_in, res_peak_ff, res_peak_in;
   status_type           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]     out_off_ff, out_off_in, out_peak_ff, out_peak_in;
   status_type           out_status_ff, out_status_in;

   logic [STEP_BITS+STEP_W-1:0] def_wide, last_wide;
   logic [CALC-1:0]      addr_max, size_ext, sum, end_ext, mask, rnd, best_ext;
   logic [ADDR_BITS+OUT_W-1:0] peak_wide, hold_wide;
   logic [ADDR_BITS-1:0] new_peak;
   logic                 sweeping, in_range, fits, overflow, kill, eligible;
   logic [IW-1:0]        rd_idx;

   assign def_wide  = {{STEP_BITS{1'b0}}, in_def_step};
   assign last_wide = {{STEP_BITS{1'b0}}, in_last_use_step};
   assign addr_max  = {{(CALC-ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};
   assign size_ext  = CALC'(size_ff);
   assign sum       = cand_ff + size_ext;
   assign best_ext  = CALC'(best_off_ff);
   assign fits      = (sum <= best_ext);
   assign end_ext   = CALC'(rd_end_ff);
   assign mask      = (CALC'(1) << align_ff) - CALC'(1);
   assign rnd       = (end_ext + mask) & ~mask;
   assign overflow  = (cand_ff > addr_max) || (sum > addr_max);
   assign new_peak  = (sum[ADDR_BITS-1:0] > peak_ff) ? sum[ADDR_BITS-1:0] : peak_ff;
   assign peak_wide = {{OUT_W{1'b0}}, (overflow ? peak_ff : new_peak)};
   assign hold_wide = {{OUT_W{1'b0}}, peak_ff};
   assign sweeping  = (cmd.op == OP_PRUNE) || (cmd.op == OP_SEARCH);
   assign in_range  = (cnt_ff < DEPTH_CNT);
   assign rd_idx    = in_range ? cnt_ff[IW-1:0] : '0;
   assign kill      = valid_ff[pidx_ff] && (rd_last_ff < def_ff);
   assign eligible  = valid_ff[pidx_ff] && (!started_ff || (rd_off_ff > prev_off_ff) ||
                      ((rd_off_ff == prev_off_ff) && (pidx_ff > prev_idx_ff)));

   assign stat.sweep_done = (cnt_ff == DEPTH_CNT) && !pv_ff;
   assign stat.has_free   = has_free_ff;
   assign stat.found      = found_ff;
   assign stat.fits       = fits;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_offset     = out_off_ff;
   assign rsp_peak_bytes = out_peak_ff;
   assign rsp_status     = out_status_ff;

   always_ff @(posedge clock) begin
      rd_off_ff  <= off_mem[rd_idx];
      rd_last_ff <= last_mem[rd_idx];
      rd_end_ff  <= end_mem[best_ff];
      if ((cmd.op == OP_PLACE) && !overflow) begin
         off_mem[free_ff]  <= cand_ff[ADDR_BITS-1:0];
         end_mem[free_ff]  <= sum[ADDR_BITS-1:0];
         last_mem[free_ff] <= last_ff;
      end
   end

   always_comb begin
      size_in       = size_ff;
      def_in        = def_ff;
      last_in       = last_ff;
      cand_in       = cand_ff;
      started_in    = started_ff;
      prev_off_in   = prev_off_ff;
      prev_idx_in   = prev_idx_ff;
      best_in       = best_ff;
      best_off_in   = best_off_ff;
      found_in      = found_ff;
      free_in       = free_ff;
      has_free_in   = has_free_ff;
      cnt_in        = '0;
      pv_in         = 1'b0;
      pidx_in       = pidx_ff;
      valid_in      = valid_ff;
      peak_in       = peak_ff;
      align_in      = csr_write_enable ? csr_write_data : align_ff;
      res_off_in    = res_off_ff;
      res_peak_in   = res_peak_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      out_off_in    = out_off_ff;
      out_peak_in   = out_peak_ff;
      out_status_in = out_status_ff;

      if (sweeping) begin
         cnt_in  = in_range ? cnt_ff + CW'(1) : cnt_ff;
         pv_in   = in_range;
         pidx_in = rd_idx;
      end

      case (cmd.op)
         OP_LOAD: begin
            size_in     = in_buffer_size;
            def_in      = def_wide[STEP_BITS-1:0];
            last_in     = last_wide[STEP_BITS-1:0];
            cand_in     = '0;
            started_in  = 1'b0;
            found_in    = 1'b0;
            has_free_in = 1'b0;
            if (in_new_plan) begin
               valid_in = '0;
               peak_in  = '0;
            end
         end
         OP_PRUNE: begin
            if (pv_ff) begin
               if (kill) valid_in[pidx_ff] = 1'b0;
               if ((!valid_ff[pidx_ff] || kill) && !has_free_ff) begin
                  has_free_in = 1'b1;
                  free_in     = pidx_ff;
               end
            end
         end
         OP_CHECK: begin
            found_in      = 1'b0;
            res_off_in    = '0;
            res_peak_in   = hold_wide[OUT_W-1:0];
            res_status_in = STATUS_FULL;
         end
         OP_SEARCH: begin
            if (pv_ff && eligible && (!found_ff || (rd_off_ff < best_off_ff))) begin
               found_in    = 1'b1;
               best_in     = pidx_ff;
               best_off_in = rd_off_ff;
            end
         end
         OP_STEP: begin
            cand_in     = rnd;
            started_in  = 1'b1;
            prev_off_in = best_off_ff;
            prev_idx_in = best_ff;
            found_in    = 1'b0;
         end
         OP_PLACE: begin
            res_peak_in = peak_wide[OUT_W-1:0];
            if (overflow) begin
               res_off_in    = '0;
               res_status_in = STATUS_OVERFLOW;
            end else begin
               res_off_in        = cand_ff[OUT_W-1:0];
               res_status_in     = STATUS_OK;
               valid_in[free_ff] = 1'b1;
               peak_in           = new_peak;
            end
         end
         OP_EMIT: begin
            rsp_valid_in  = 1'b1;
            out_off_in    = res_off_ff;
            out_peak_in   = res_peak_ff;
            out_status_in = res_status_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         peak_ff      <= '0;
         align_ff     <= ALIGN_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         has_free_ff  <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         peak_ff      <= peak_in;
         align_ff     <= align_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         found_ff     <= found_in;
         has_free_ff  <= has_free_in;
         started_ff   <= started_in;
      end
      size_ff       <= size_in;
      def_ff        <= def_in;
      last_ff       <= last_in;
      cand_ff       <= cand_in;
      prev_off_ff   <= prev_off_in;
      prev_idx_ff   <= prev_idx_in;
      best_ff       <= best_in;
      best_off_ff   <= best_off_in;
      free_ff       <= free_in;
      pidx_ff       <= pidx_in;
      res_off_ff    <= res_off_in;
      res_peak_ff   <= res_peak_in;
      res_status_ff <= res_status_in;
      out_off_ff    <= out_off_in;
      out_peak_ff   <= out_peak_in;
      out_status_ff <= out_status_in;
   end

endmodule

@@ sv/tensor_offset_first_fit_planner_top.sv @@
// top level: first-fit tensor offset planner
`timescale 1ns / 1ps
// Each request transaction places one buffer. The block first sweeps the live
// table once to release expired intervals and find a free slot, then walks
// live intervals in offset order; every visited interval costs one full
// ordered-minimum sweep of the offset memory plus a fetch state that tests the
// gap before it, and a step past its rounded-up end when the gap is too small.
// A full table answers straight after the prune sweep and the check, with no
// search. The response register lets the next request start while a result
// waits; the result after it waits until that one is taken. The user is to
// write alignment through csr_write_enable/csr_write_data only when idle; the
// block itself does not enforce it.
module tensor_offset_first_fit_planner_top import tofp_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
   parameter int ADDR_BITS   = ADDR_BITS_DEFAULT,
   parameter int STEP_BITS   = STEP_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   tofp_req_if.sink           req_port,
   tofp_rsp_if.source         rsp_port,
   input  logic               csr_write_enable,
   input  logic [ALIGN_W-1:0] csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   tofp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tofp_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_BITS   (ADDR_BITS),
      .STEP_BITS   (STEP_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_new_plan      (req_port.new_plan),
      .in_buffer_size   (req_port.buffer_size),
      .in_def_step      (req_port.def_step),
      .in_last_use_step (req_port.last_use_step),
      .rsp_valid        (rsp_port.valid),
      .rsp_ready        (rsp_port.ready),
      .rsp_offset       (rsp_port.offset),
      .rsp_peak_bytes   (rsp_port.peak_bytes),
      .rsp_status       (rsp_port.status)
   );

endmodule

@@ sv/tofp_checker.sv @@
// checker: port-level assertions, bound to the top level
`timescale 1ns / 1ps
module tofp_checker import tofp_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] rsp_offset,
   input logic [1:0]       rsp_status
);

   // one transaction at a time in the planner
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_offset == '0)
      else $error("failed placement with nonzero offset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_offset) && $stable(rsp_status))
      else $error("response dropped or changed while stalled");

   // a response never rises straight after an accepted request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid || !$rose(rsp_valid))
      else $error("response right after request");

endmodule

bind tensor_offset_first_fit_planner_top tofp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_offset (rsp_port.offset),
   .rsp_status (rsp_port.status)
);
